FILE: hw/rtl/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Assertion macros used by the checker file of the project.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset
`define CHK_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off in reset
`define CHK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ntri_pkg.sv
// ============================================================================
// ntri_pkg
// Shared widths, constants and types of the nearest in-triangle target select.
// ============================================================================
package ntri_pkg;

    localparam int COORD_BITS   = 24;
    localparam int ID_BITS      = 10;
    localparam int FRAC_BITS    = 8;
    localparam int CFG_IDX_BITS = 3;

    // Apex-relative differences, products and cross-product sums
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int CROSS_BITS = PROD_BITS + 2;
    // Sum of three squares of at most 2^(2*COORD_BITS) stays below 2^PROD_BITS
    localparam int DIST_BITS  = PROD_BITS;

    // Marker height: 30.0 in the coordinate fixed-point format
    localparam logic signed [COORD_BITS:0] MARKER_Y_OFFSET =
        (COORD_BITS + 1)'(30 * (1 << FRAC_BITS));
    localparam logic signed [COORD_BITS:0] MARKER_Y_MAX =
        (COORD_BITS + 1)'((64'd1 << (COORD_BITS - 1)) - 64'd1);

    // Configuration register map
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ORIGIN_X       = 3'd0,
        CFG_ORIGIN_Y       = 3'd1,
        CFG_ORIGIN_Z       = 3'd2,
        CFG_LEFT_CORNER_X  = 3'd3,
        CFG_LEFT_CORNER_Z  = 3'd4,
        CFG_RIGHT_CORNER_X = 3'd5,
        CFG_RIGHT_CORNER_Z = 3'd6
    } cfg_idx_t;

    // Triangle geometry as held in the configuration registers
    typedef struct packed {
        logic signed [COORD_BITS-1:0] origin_x;
        logic signed [COORD_BITS-1:0] origin_y;
        logic signed [COORD_BITS-1:0] origin_z;
        logic signed [COORD_BITS-1:0] left_x;
        logic signed [COORD_BITS-1:0] left_z;
        logic signed [COORD_BITS-1:0] right_x;
        logic signed [COORD_BITS-1:0] right_z;
    } geom_cfg_t;

    // One judged object, handed from the geometry pipe to the best tracker
    typedef struct packed {
        logic                         valid;
        logic                         last;
        logic                         sel;
        logic [DIST_BITS-1:0]         dist_sq;
        logic [ID_BITS-1:0]           id;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] my;
        logic signed [COORD_BITS-1:0] z;
    } judged_t;

endpackage

FILE: hw/rtl/ntri_geom.sv
// ============================================================================
// ntri_geom
// Four-stage pipe: input register, products, cross sums, inside test.
// ============================================================================
module ntri_geom
    import ntri_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         accept,
    input  logic signed [COORD_BITS-1:0] obj_x,
    input  logic signed [COORD_BITS-1:0] obj_y,
    input  logic signed [COORD_BITS-1:0] obj_z,
    input  logic [ID_BITS-1:0]           obj_id,
    input  logic                         is_candidate,
    input  logic                         last_item,
    input  geom_cfg_t                    cfg,
    output judged_t                      judged
);

    // ---------------- stage 0: input register ----------------
    logic                         s0_valid_reg;
    logic signed [COORD_BITS-1:0] s0_x_reg, s0_y_reg, s0_z_reg;
    logic [ID_BITS-1:0]           s0_id_reg;
    logic                         s0_cand_reg, s0_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_x_reg    <= obj_x;
            s0_y_reg    <= obj_y;
            s0_z_reg    <= obj_z;
            s0_id_reg   <= obj_id;
            s0_cand_reg <= is_candidate;
            s0_last_reg <= last_item;
        end
    end

    // ---------------- stage 1: differences and products ----------------
    logic signed [DIFF_BITS-1:0]  dx, dy, dz, v1x, v1z, v2x, v2z;
    logic signed [COORD_BITS:0]   ysum;
    logic signed [COORD_BITS-1:0] my_next;

    always_comb
    begin
        dx   = $signed({s0_x_reg[COORD_BITS-1], s0_x_reg})
             - $signed({cfg.origin_x[COORD_BITS-1], cfg.origin_x});
        dy   = $signed({s0_y_reg[COORD_BITS-1], s0_y_reg})
             - $signed({cfg.origin_y[COORD_BITS-1], cfg.origin_y});
        dz   = $signed({s0_z_reg[COORD_BITS-1], s0_z_reg})
             - $signed({cfg.origin_z[COORD_BITS-1], cfg.origin_z});
        v1x  = $signed({cfg.left_x[COORD_BITS-1], cfg.left_x})
             - $signed({cfg.origin_x[COORD_BITS-1], cfg.origin_x});
        v1z  = $signed({cfg.left_z[COORD_BITS-1], cfg.left_z})
             - $signed({cfg.origin_z[COORD_BITS-1], cfg.origin_z});
        v2x  = $signed({cfg.right_x[COORD_BITS-1], cfg.right_x})
             - $signed({cfg.origin_x[COORD_BITS-1], cfg.origin_x});
        v2z  = $signed({cfg.right_z[COORD_BITS-1], cfg.right_z})
             - $signed({cfg.origin_z[COORD_BITS-1], cfg.origin_z});
        // Marker height only ever saturates upwards
        ysum = $signed({s0_y_reg[COORD_BITS-1], s0_y_reg}) + MARKER_Y_OFFSET;
        if (ysum > MARKER_Y_MAX)
        begin
            my_next = MARKER_Y_MAX[COORD_BITS-1:0];
        end
        else
        begin
            my_next = ysum[COORD_BITS-1:0];
        end
    end

    logic                         s1_valid_reg;
    logic signed [PROD_BITS-1:0]  s1_dxx_reg, s1_dyy_reg, s1_dzz_reg;
    logic signed [PROD_BITS-1:0]  s1_pa_reg, s1_pb_reg, s1_pc_reg, s1_pd_reg;
    logic signed [PROD_BITS-1:0]  s1_ma_reg, s1_mb_reg;
    logic [ID_BITS-1:0]           s1_id_reg;
    logic                         s1_cand_reg, s1_last_reg;
    logic signed [COORD_BITS-1:0] s1_x_reg, s1_my_reg, s1_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_dxx_reg  <= dx * dx;
            s1_dyy_reg  <= dy * dy;
            s1_dzz_reg  <= dz * dz;
            s1_pa_reg   <= dx * v2z;
            s1_pb_reg   <= dz * v2x;
            s1_pc_reg   <= dz * v1x;
            s1_pd_reg   <= dx * v1z;
            s1_ma_reg   <= v1x * v2z;
            s1_mb_reg   <= v1z * v2x;
            s1_id_reg   <= s0_id_reg;
            s1_cand_reg <= s0_cand_reg;
            s1_last_reg <= s0_last_reg;
            s1_x_reg    <= s0_x_reg;
            s1_my_reg   <= my_next;
            s1_z_reg    <= s0_z_reg;
        end
    end

    // ---------------- stage 2: cross sums and distance ----------------
    logic signed [CROSS_BITS-1:0] f1_next, f2_next, fs_next, m_next;
    logic [DIST_BITS-1:0]         dist_next;

    always_comb
    begin
        f1_next   = CROSS_BITS'(s1_pa_reg) - CROSS_BITS'(s1_pb_reg);
        f2_next   = CROSS_BITS'(s1_pc_reg) - CROSS_BITS'(s1_pd_reg);
        fs_next   = CROSS_BITS'(s1_pa_reg) - CROSS_BITS'(s1_pb_reg)
                  + CROSS_BITS'(s1_pc_reg) - CROSS_BITS'(s1_pd_reg);
        m_next    = CROSS_BITS'(s1_ma_reg) - CROSS_BITS'(s1_mb_reg);
        // Squares are non-negative, so the low bits carry them unsigned
        dist_next = DIST_BITS'(s1_dxx_reg) + DIST_BITS'(s1_dyy_reg)
                  + DIST_BITS'(s1_dzz_reg);
    end

    logic                         s2_valid_reg;
    logic signed [CROSS_BITS-1:0] s2_f1_reg, s2_f2_reg, s2_fs_reg, s2_m_reg;
    logic [DIST_BITS-1:0]         s2_dist_reg;
    logic [ID_BITS-1:0]           s2_id_reg;
    logic                         s2_cand_reg, s2_last_reg;
    logic signed [COORD_BITS-1:0] s2_x_reg, s2_my_reg, s2_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_f1_reg   <= f1_next;
            s2_f2_reg   <= f2_next;
            s2_fs_reg   <= fs_next;
            s2_m_reg    <= m_next;
            s2_dist_reg <= dist_next;
            s2_id_reg   <= s1_id_reg;
            s2_cand_reg <= s1_cand_reg;
            s2_last_reg <= s1_last_reg;
            s2_x_reg    <= s1_x_reg;
            s2_my_reg   <= s1_my_reg;
            s2_z_reg    <= s1_z_reg;
        end
    end

    // ---------------- stage 3: inside test ----------------
    // A negative area flips every bound instead of negating the sums
    logic m_pos, m_neg, inside_pos, inside_neg, sel_next;

    always_comb
    begin
        m_pos      = !s2_m_reg[CROSS_BITS-1] && (s2_m_reg != '0);
        m_neg      = s2_m_reg[CROSS_BITS-1];
        inside_pos = (s2_f1_reg >= 0) && (s2_f2_reg >= 0)
                  && (s2_f1_reg <= s2_m_reg) && (s2_f2_reg <= s2_m_reg)
                  && (s2_fs_reg <= s2_m_reg);
        inside_neg = (s2_f1_reg <= 0) && (s2_f2_reg <= 0)
                  && (s2_f1_reg >= s2_m_reg) && (s2_f2_reg >= s2_m_reg)
                  && (s2_fs_reg >= s2_m_reg);
        sel_next   = s2_cand_reg && ((m_pos && inside_pos) || (m_neg && inside_neg));
    end

    judged_t s3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg <= '0;
        end
        else if (advance)
        begin
            s3_reg.valid   <= s2_valid_reg;
            s3_reg.last    <= s2_last_reg;
            s3_reg.sel     <= sel_next;
            s3_reg.dist_sq <= s2_dist_reg;
            s3_reg.id      <= s2_id_reg;
            s3_reg.x       <= s2_x_reg;
            s3_reg.my      <= s2_my_reg;
            s3_reg.z       <= s2_z_reg;
        end
    end

    assign judged = s3_reg;

endmodule

FILE: hw/rtl/ntri_best.sv
// ============================================================================
// ntri_best
// Running nearest-object register and the result register of a scan.
// ============================================================================
module ntri_best
    import ntri_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  judged_t                      judged,
    output logic                         advance,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic                         found,
    output logic [ID_BITS-1:0]           target_id,
    output logic signed [COORD_BITS-1:0] marker_x,
    output logic signed [COORD_BITS-1:0] marker_y,
    output logic signed [COORD_BITS-1:0] marker_z
);

    logic                         best_valid_reg;
    logic [DIST_BITS-1:0]         best_dist_reg;
    logic [ID_BITS-1:0]           best_id_reg;
    logic signed [COORD_BITS-1:0] best_x_reg, best_my_reg, best_z_reg;

    logic                         res_valid_reg, found_reg;
    logic [ID_BITS-1:0]           target_id_reg;
    logic signed [COORD_BITS-1:0] marker_x_reg, marker_y_reg, marker_z_reg;

    logic take, upd, close_scan, res_valid_next;

    // Pipe holds only when a scan end meets a result not yet taken
    always_comb
    begin
        advance        = !(judged.valid && judged.last && res_valid_reg && res_stall);
        take           = judged.valid && advance;
        // Strictly nearer replaces, ties keep the earlier object
        upd            = judged.sel && (!best_valid_reg || (judged.dist_sq < best_dist_reg));
        close_scan     = take && judged.last;
        res_valid_next = (res_valid_reg && res_stall) || close_scan;
    end

    // Control: best flag and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (close_scan)
            begin
                best_valid_reg <= 1'b0;
            end
            else if (take && upd)
            begin
                best_valid_reg <= 1'b1;
            end
        end
    end

    // Best payload
    always_ff @(posedge clk)
    begin
        if (take && upd)
        begin
            best_dist_reg <= judged.dist_sq;
            best_id_reg   <= judged.id;
            best_x_reg    <= judged.x;
            best_my_reg   <= judged.my;
            best_z_reg    <= judged.z;
        end
    end

    // Result word: the scan's last object is judged before closing
    always_ff @(posedge clk)
    begin
        if (close_scan)
        begin
            if (upd)
            begin
                found_reg     <= 1'b1;
                target_id_reg <= judged.id;
                marker_x_reg  <= judged.x;
                marker_y_reg  <= judged.my;
                marker_z_reg  <= judged.z;
            end
            else if (best_valid_reg)
            begin
                found_reg     <= 1'b1;
                target_id_reg <= best_id_reg;
                marker_x_reg  <= best_x_reg;
                marker_y_reg  <= best_my_reg;
                marker_z_reg  <= best_z_reg;
            end
            else
            begin
                found_reg     <= 1'b0;
                target_id_reg <= '0;
                marker_x_reg  <= '0;
                marker_y_reg  <= '0;
                marker_z_reg  <= '0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign found     = found_reg;
    assign target_id = target_id_reg;
    assign marker_x  = marker_x_reg;
    assign marker_y  = marker_y_reg;
    assign marker_z  = marker_z_reg;

endmodule

FILE: hw/rtl/nearest_point_in_triangle_select.sv
// ============================================================================
// nearest_point_in_triangle_select
// Keeps the candidate object nearest the apex inside an XZ triangle per scan.
// ============================================================================
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  object   | obj_valid/obj_stall  | obj_x obj_y obj_z obj_id is_candidate last_item
//  result   | res_valid/res_stall  | found target_id marker_x marker_y marker_z
//  config   | cfg_valid/cfg_ready  | cfg_index cfg_data
//
//  One object word per cycle while the pipe is not stalled; the result of a scan
//  is in the result register once its last word has passed the products, sums, test and best registers.
//  The pipe stalls only while a last word waits behind an untaken result.
//  Reset clears the configuration, the pipe valids and the running best.
//  cfg_ready is always high.
// ============================================================================
module nearest_point_in_triangle_select
    import ntri_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         obj_valid,
    output logic                         obj_stall,
    input  logic signed [COORD_BITS-1:0] obj_x,
    input  logic signed [COORD_BITS-1:0] obj_y,
    input  logic signed [COORD_BITS-1:0] obj_z,
    input  logic [ID_BITS-1:0]           obj_id,
    input  logic                         is_candidate,
    input  logic                         last_item,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic                         found,
    output logic [ID_BITS-1:0]           target_id,
    output logic signed [COORD_BITS-1:0] marker_x,
    output logic signed [COORD_BITS-1:0] marker_y,
    output logic signed [COORD_BITS-1:0] marker_z,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [COORD_BITS-1:0]        cfg_data
);

    geom_cfg_t cfg_reg;
    judged_t   judged;
    logic      advance;
    logic      accept;

    // Configuration registers; unmapped indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ORIGIN_X:       cfg_reg.origin_x <= cfg_data;
                CFG_ORIGIN_Y:       cfg_reg.origin_y <= cfg_data;
                CFG_ORIGIN_Z:       cfg_reg.origin_z <= cfg_data;
                CFG_LEFT_CORNER_X:  cfg_reg.left_x   <= cfg_data;
                CFG_LEFT_CORNER_Z:  cfg_reg.left_z   <= cfg_data;
                CFG_RIGHT_CORNER_X: cfg_reg.right_x  <= cfg_data;
                CFG_RIGHT_CORNER_Z: cfg_reg.right_z  <= cfg_data;
                default:            cfg_reg          <= cfg_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign obj_stall = !advance;
    assign accept    = obj_valid && advance;

    ntri_geom u_geom (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .accept       (accept),
        .obj_x        (obj_x),
        .obj_y        (obj_y),
        .obj_z        (obj_z),
        .obj_id       (obj_id),
        .is_candidate (is_candidate),
        .last_item    (last_item),
        .cfg          (cfg_reg),
        .judged       (judged)
    );

    ntri_best u_best (
        .clk       (clk),
        .rst_n     (rst_n),
        .judged    (judged),
        .advance   (advance),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .found     (found),
        .target_id (target_id),
        .marker_x  (marker_x),
        .marker_y  (marker_y),
        .marker_z  (marker_z)
    );

endmodule

FILE: hw/rtl/ntri_chk.sv
// ============================================================================
// ntri_chk
// Port-level checks of the nearest in-triangle target select.
// ============================================================================
`include "assert_macros.svh"

module ntri_chk
    import ntri_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         obj_valid,
    input logic                         obj_stall,
    input logic signed [COORD_BITS-1:0] obj_x,
    input logic signed [COORD_BITS-1:0] obj_y,
    input logic signed [COORD_BITS-1:0] obj_z,
    input logic [ID_BITS-1:0]           obj_id,
    input logic                         is_candidate,
    input logic                         last_item,
    input logic                         res_valid,
    input logic                         res_stall,
    input logic                         found,
    input logic [ID_BITS-1:0]           target_id,
    input logic signed [COORD_BITS-1:0] marker_x,
    input logic signed [COORD_BITS-1:0] marker_y,
    input logic signed [COORD_BITS-1:0] marker_z,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic [CFG_IDX_BITS-1:0]      cfg_index,
    input logic [COORD_BITS-1:0]        cfg_data
);

    localparam logic signed [COORD_BITS:0] MARKER_Y_MIN =
        -(MARKER_Y_MAX + (COORD_BITS + 1)'(1)) + MARKER_Y_OFFSET;

    // A waiting result word stays until it is taken
    `CHK_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid, "result dropped while stalled")

    // Object input is only held back by a full, stalled result register
    `CHK_ASSERT_NOW(a_stall_cause, clk, rst_n, obj_stall, res_valid && res_stall, "object stall without a blocked result")

    // An empty scan reports all-zero fields
    `CHK_ASSERT_NOW(a_empty_zero, clk, rst_n, res_valid && !found, (target_id == '0) && (marker_x == '0) && (marker_y == '0) && (marker_z == '0), "empty scan result not zero")

    // The marker sits at least the offset above the lowest coordinate
    `CHK_ASSERT_NOW(a_marker_floor, clk, rst_n, res_valid && found, $signed({marker_y[COORD_BITS-1], marker_y}) >= MARKER_Y_MIN, "marker height below offset floor")

endmodule

bind nearest_point_in_triangle_select ntri_chk u_ntri_chk (.*);
